### design/cau_pkg.sv
// Package for the complex arithmetic unit: widths, command codes, stage records
// and the saturation helper. It depends on nothing else.

package cau_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int PART_WIDTH = 32;

	localparam int PW     = PART_WIDTH;
	localparam int PROD_W = 2 * PW;
	localparam int SUM_W  = 2 * PW + 1;
	localparam int DEN_W  = 2 * PW;
	localparam int MAG_W  = 2 * PW;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int DIV_STEPS = PW;
	localparam int NSTG   = DIV_STEPS + 4;

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((65'sd1 <<< (PW - 1)) - 65'sd1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
	localparam logic [PW-1:0] HALF = PW'(1) << (PW - 1);

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [PW-1:0] value;
		logic          clip;
	} sat_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [PW:0]       as_re;
		logic signed [PW:0]       as_im;
		logic signed [PROD_W-1:0] p_rr;
		logic signed [PROD_W-1:0] p_ii;
		logic signed [PROD_W-1:0] p_ri;
		logic signed [PROD_W-1:0] p_ir;
		logic signed [PROD_W-1:0] p_br2;
		logic signed [PROD_W-1:0] p_bi2;
	} prod_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [SUM_W-1:0] sum_re;
		logic signed [SUM_W-1:0] sum_im;
		logic [DEN_W-1:0]        den;
	} sum_t;

	typedef struct packed {
		logic             is_div;
		logic             dz;
		logic             clip;
		logic             ovf_re;
		logic             ovf_im;
		logic             neg_re;
		logic             neg_im;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] r_re;
		logic [DEN_W-1:0] r_im;
		logic [PW-1:0]    nq_re;
		logic [PW-1:0]    nq_im;
	} div_t;

	function automatic sat_t sat_part(input logic signed [SUM_W-1:0] x);
		sat_t s;
		if (x > SAT_MAX) begin
			s.value = SAT_MAX[PW-1:0];
			s.clip  = 1'b1;
		end else if (x < SAT_MIN) begin
			s.value = SAT_MIN[PW-1:0];
			s.clip  = 1'b1;
		end else begin
			s.value = x[PW-1:0];
			s.clip  = 1'b0;
		end
		return s;
	endfunction

endpackage

### design/complex_arith_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two Q16.16 complex
// operands. Every request passes through the same pipeline of 36 register
// stages (products, sums, setup, 32 one-bit divide steps, output), and one
// request is taken every cycle unless a stalled output has filled them all.
// A stalled output lets empty stages upstream keep filling. Depends on cau_pkg.

module complex_arith_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    command,
	input  logic signed [cau_pkg::PW-1:0] a_real,
	input  logic signed [cau_pkg::PW-1:0] a_imag,
	input  logic signed [cau_pkg::PW-1:0] b_real,
	input  logic signed [cau_pkg::PW-1:0] b_imag,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic signed [cau_pkg::PW-1:0] result_real,
	output logic signed [cau_pkg::PW-1:0] result_imag,
	output logic                          divide_by_zero,
	output logic                          saturated
);

	localparam int N = cau_pkg::NSTG;

	logic [N-1:0]  vld_q;
	logic [N-1:0]  adv;
	logic [N-1:0]  vin;
	cau_pkg::sum_t sum_s2;
	cau_pkg::div_t div_s [0:cau_pkg::DIV_STEPS];

	assign adv[N-1] = ~vld_q[N-1] | rsp_ready;
	assign vin[0]   = req_valid;

	genvar k;
	generate
		for (k = 0; k < N - 1; k++) begin : g_adv
			assign adv[k]   = ~vld_q[k] | adv[k+1];
			assign vin[k+1] = vld_q[k];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (adv & vin) | (~adv & vld_q);
		end
	end

	assign req_ready = adv[0];
	assign rsp_valid = vld_q[N-1];

	cau_front u_front (
		.clk    (clk),
		.en_s1  (adv[0]),
		.en_s2  (adv[1]),
		.command(command),
		.a_real (a_real),
		.a_imag (a_imag),
		.b_real (b_real),
		.b_imag (b_imag),
		.sum_s2 (sum_s2)
	);

	cau_setup u_setup (
		.clk   (clk),
		.en    (adv[2]),
		.sum_s2(sum_s2),
		.div_s3(div_s[0])
	);

	generate
		for (k = 0; k < cau_pkg::DIV_STEPS; k++) begin : g_div
			cau_div_step u_step (
				.clk  (clk),
				.en   (adv[k+3]),
				.d_in (div_s[k]),
				.d_out(div_s[k+1])
			);
		end
	endgenerate

	cau_final u_final (
		.clk           (clk),
		.en            (adv[N-1]),
		.d_in          (div_s[cau_pkg::DIV_STEPS]),
		.result_real   (result_real),
		.result_imag   (result_imag),
		.divide_by_zero(divide_by_zero),
		.saturated     (saturated)
	);

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && divide_by_zero |-> result_real == '0 && result_imag == '0 && !saturated)
		else $error("divide by zero result is not zero");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without an output stall");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready && vld_q == '1 |-> !req_ready)
		else $error("request taken into a full stalled pipeline");

endmodule

### design/cau_front.sv
// First two pipeline stages: the six operand products and the add or subtract,
// then the sums that feed multiply and divide. Depends on cau_pkg.

module cau_front (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [1:0]                    command,
	input  logic signed [cau_pkg::PW-1:0] a_real,
	input  logic signed [cau_pkg::PW-1:0] a_imag,
	input  logic signed [cau_pkg::PW-1:0] b_real,
	input  logic signed [cau_pkg::PW-1:0] b_imag,
	output cau_pkg::sum_t                 sum_s2
);

	cau_pkg::prod_t prod_s1;
	cau_pkg::cmd_t  cmd;

	assign cmd = cau_pkg::cmd_t'(command);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1.cmd <= cmd;
			if (cmd == cau_pkg::CMD_SUB) begin
				prod_s1.as_re <= (cau_pkg::PW+1)'(a_real) - (cau_pkg::PW+1)'(b_real);
				prod_s1.as_im <= (cau_pkg::PW+1)'(a_imag) - (cau_pkg::PW+1)'(b_imag);
			end else begin
				prod_s1.as_re <= (cau_pkg::PW+1)'(a_real) + (cau_pkg::PW+1)'(b_real);
				prod_s1.as_im <= (cau_pkg::PW+1)'(a_imag) + (cau_pkg::PW+1)'(b_imag);
			end
			prod_s1.p_rr  <= cau_pkg::PROD_W'(a_real) * cau_pkg::PROD_W'(b_real);
			prod_s1.p_ii  <= cau_pkg::PROD_W'(a_imag) * cau_pkg::PROD_W'(b_imag);
			prod_s1.p_ri  <= cau_pkg::PROD_W'(a_real) * cau_pkg::PROD_W'(b_imag);
			prod_s1.p_ir  <= cau_pkg::PROD_W'(a_imag) * cau_pkg::PROD_W'(b_real);
			prod_s1.p_br2 <= cau_pkg::PROD_W'(b_real) * cau_pkg::PROD_W'(b_real);
			prod_s1.p_bi2 <= cau_pkg::PROD_W'(b_imag) * cau_pkg::PROD_W'(b_imag);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2.cmd <= prod_s1.cmd;
			sum_s2.den <= cau_pkg::DEN_W'($unsigned(prod_s1.p_br2))
				+ cau_pkg::DEN_W'($unsigned(prod_s1.p_bi2));
			case (prod_s1.cmd)
				cau_pkg::CMD_MUL: begin
					sum_s2.sum_re <= cau_pkg::SUM_W'(prod_s1.p_rr) - cau_pkg::SUM_W'(prod_s1.p_ii);
					sum_s2.sum_im <= cau_pkg::SUM_W'(prod_s1.p_ri) + cau_pkg::SUM_W'(prod_s1.p_ir);
				end
				cau_pkg::CMD_DIV: begin
					sum_s2.sum_re <= cau_pkg::SUM_W'(prod_s1.p_rr) + cau_pkg::SUM_W'(prod_s1.p_ii);
					sum_s2.sum_im <= cau_pkg::SUM_W'(prod_s1.p_ir) - cau_pkg::SUM_W'(prod_s1.p_ri);
				end
				default: begin
					sum_s2.sum_re <= cau_pkg::SUM_W'(prod_s1.as_re);
					sum_s2.sum_im <= cau_pkg::SUM_W'(prod_s1.as_im);
				end
			endcase
		end
	end

endmodule

### design/cau_setup.sv
// Third stage: saturates add, subtract and multiply results and prepares the
// divider lanes (magnitude, sign, overflow test). Depends on cau_pkg.

module cau_setup (
	input  logic          clk,
	input  logic          en,
	input  cau_pkg::sum_t sum_s2,
	output cau_pkg::div_t div_s3
);

	logic signed [cau_pkg::SUM_W-1:0] sh_re, sh_im, mw_re, mw_im;
	logic [cau_pkg::NUM_W-1:0]        n_re, n_im;
	logic [cau_pkg::DEN_W-1:0]        hi_re, hi_im;
	cau_pkg::sat_t                    s_re, s_im;
	cau_pkg::div_t                    d;

	always_comb begin
		sh_re = sum_s2.sum_re >>> cau_pkg::FRAC_BITS;
		sh_im = sum_s2.sum_im >>> cau_pkg::FRAC_BITS;
		mw_re = sum_s2.sum_re[cau_pkg::SUM_W-1] ? -sum_s2.sum_re : sum_s2.sum_re;
		mw_im = sum_s2.sum_im[cau_pkg::SUM_W-1] ? -sum_s2.sum_im : sum_s2.sum_im;
		n_re  = cau_pkg::NUM_W'(mw_re[cau_pkg::MAG_W-1:0]) << cau_pkg::FRAC_BITS;
		n_im  = cau_pkg::NUM_W'(mw_im[cau_pkg::MAG_W-1:0]) << cau_pkg::FRAC_BITS;
		hi_re = cau_pkg::DEN_W'(n_re[cau_pkg::NUM_W-1:cau_pkg::PW]);
		hi_im = cau_pkg::DEN_W'(n_im[cau_pkg::NUM_W-1:cau_pkg::PW]);
		if (sum_s2.cmd == cau_pkg::CMD_MUL) begin
			s_re = cau_pkg::sat_part(sh_re);
			s_im = cau_pkg::sat_part(sh_im);
		end else begin
			s_re = cau_pkg::sat_part(sum_s2.sum_re);
			s_im = cau_pkg::sat_part(sum_s2.sum_im);
		end

		d        = '0;
		d.den    = sum_s2.den;
		d.neg_re = sum_s2.sum_re[cau_pkg::SUM_W-1];
		d.neg_im = sum_s2.sum_im[cau_pkg::SUM_W-1];
		d.ovf_re = hi_re >= sum_s2.den;
		d.ovf_im = hi_im >= sum_s2.den;
		d.r_re   = hi_re;
		d.r_im   = hi_im;
		if (sum_s2.cmd == cau_pkg::CMD_DIV) begin
			if (sum_s2.den == '0) begin
				d.dz = 1'b1;
			end else begin
				d.is_div = 1'b1;
				d.nq_re  = n_re[cau_pkg::PW-1:0];
				d.nq_im  = n_im[cau_pkg::PW-1:0];
			end
		end else begin
			d.nq_re = s_re.value;
			d.nq_im = s_im.value;
			d.clip  = s_re.clip | s_im.clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3 <= d;
		end
	end

endmodule

### design/cau_div_step.sv
// One restoring divide step for both lanes: one quotient bit per part.
// Depends on cau_pkg.

module cau_div_step (
	input  logic          clk,
	input  logic          en,
	input  cau_pkg::div_t d_in,
	output cau_pkg::div_t d_out
);

	logic [cau_pkg::DEN_W:0] t_re, t_im, dd;
	logic                    ge_re, ge_im;
	cau_pkg::div_t           d;

	always_comb begin
		dd    = {1'b0, d_in.den};
		t_re  = {d_in.r_re, d_in.nq_re[cau_pkg::PW-1]};
		t_im  = {d_in.r_im, d_in.nq_im[cau_pkg::PW-1]};
		ge_re = t_re >= dd;
		ge_im = t_im >= dd;
		d     = d_in;
		if (d_in.is_div) begin
			d.r_re  = ge_re ? cau_pkg::DEN_W'(t_re - dd) : t_re[cau_pkg::DEN_W-1:0];
			d.r_im  = ge_im ? cau_pkg::DEN_W'(t_im - dd) : t_im[cau_pkg::DEN_W-1:0];
			d.nq_re = {d_in.nq_re[cau_pkg::PW-2:0], ge_re};
			d.nq_im = {d_in.nq_im[cau_pkg::PW-2:0], ge_im};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d;
		end
	end

endmodule

### design/cau_final.sv
// Output stage: applies the sign to divide quotients, saturates them and
// registers the result fields. Depends on cau_pkg.

module cau_final (
	input  logic                          clk,
	input  logic                          en,
	input  cau_pkg::div_t                 d_in,
	output logic signed [cau_pkg::PW-1:0] result_real,
	output logic signed [cau_pkg::PW-1:0] result_imag,
	output logic                          divide_by_zero,
	output logic                          saturated
);

	logic [cau_pkg::PW-1:0] v_re, v_im;
	logic                   c_re, c_im;

	always_comb begin
		if (d_in.neg_re) begin
			c_re = d_in.ovf_re || (d_in.nq_re > cau_pkg::HALF);
			v_re = c_re ? cau_pkg::HALF : -d_in.nq_re;
		end else begin
			c_re = d_in.ovf_re || (d_in.nq_re >= cau_pkg::HALF);
			v_re = c_re ? ~cau_pkg::HALF : d_in.nq_re;
		end
		if (d_in.neg_im) begin
			c_im = d_in.ovf_im || (d_in.nq_im > cau_pkg::HALF);
			v_im = c_im ? cau_pkg::HALF : -d_in.nq_im;
		end else begin
			c_im = d_in.ovf_im || (d_in.nq_im >= cau_pkg::HALF);
			v_im = c_im ? ~cau_pkg::HALF : d_in.nq_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			divide_by_zero <= d_in.dz;
			if (d_in.is_div) begin
				result_real <= v_re;
				result_imag <= v_im;
				saturated   <= c_re | c_im;
			end else begin
				result_real <= d_in.nq_re;
				result_imag <= d_in.nq_im;
				saturated   <= d_in.clip;
			end
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for complex_arith_unit: predicts each complex result with
// wide exact arithmetic and compares it in order. Depends on cau_pkg and the RTL.

module tb_top;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        dz;
		logic        sat;
	} cplx_res_t;

	class cplx_scoreboard;
		cplx_res_t pending[$];
		int mismatches;

		function logic signed [127:0] clip32(input logic signed [127:0] v, ref logic c);
			if (v > 128'sd2147483647) begin
				c = 1'b1;
				return 128'sd2147483647;
			end
			if (v < -128'sd2147483648) begin
				c = 1'b1;
				return -128'sd2147483648;
			end
			return v;
		endfunction

		function logic signed [127:0] div_trunc(input logic signed [127:0] n,
				input logic signed [127:0] d);
			logic neg;
			logic [127:0] mag;
			logic [127:0] q;
			neg = n < 0;
			mag = neg ? -n : n;
			q = (mag << 16) / d;
			return neg ? -$signed(q) : $signed(q);
		endfunction

		function void note_request(input cau_pkg::cmd_t cmd, input logic signed [31:0] ar,
				input logic signed [31:0] ai, input logic signed [31:0] br,
				input logic signed [31:0] bi);
			logic signed [127:0] xr, xi, yr, yi, re, im, den;
			cplx_res_t r;
			logic c;
			xr = 128'(ar); xi = 128'(ai); yr = 128'(br); yi = 128'(bi);
			c = 1'b0;
			r.dz = 1'b0;
			case (cmd)
				cau_pkg::CMD_ADD: begin re = xr + yr; im = xi + yi; end
				cau_pkg::CMD_SUB: begin re = xr - yr; im = xi - yi; end
				cau_pkg::CMD_MUL: begin
					re = (xr * yr - xi * yi) >>> 16;
					im = (xr * yi + xi * yr) >>> 16;
				end
				default: begin
					den = yr * yr + yi * yi;
					if (den == '0) begin
						r.dz = 1'b1;
						re = '0;
						im = '0;
					end else begin
						re = div_trunc(xr * yr + xi * yi, den);
						im = div_trunc(xi * yr - xr * yi, den);
					end
				end
			endcase
			r.re = 32'(clip32(re, c));
			r.im = 32'(clip32(im, c));
			r.sat = c;
			pending.push_back(r);
		endfunction

		function void check_result(input logic [31:0] re, input logic [31:0] im,
				input logic dz, input logic sat);
			cplx_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result re=%h im=%h", re, im);
				return;
			end
			e = pending.pop_front();
			if (e.re !== re || e.im !== im || e.dz !== dz || e.sat !== sat) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: exp re=%h im=%h dz=%b sat=%b, got re=%h im=%h dz=%b sat=%b",
						e.re, e.im, e.dz, e.sat, re, im, dz, sat);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] command = '0;
	logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic signed [31:0] result_real, result_imag;
	logic divide_by_zero, saturated;

	cplx_scoreboard board = new();
	int send_idle;
	int recv_stall;
	bit hold_off;
	int quiet_cycles = 0;

	complex_arith_unit DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (req_valid && req_ready)
			board.note_request(cau_pkg::cmd_t'(command), a_real, a_imag, b_real, b_imag);
		if (rsp_valid && rsp_ready)
			board.check_result(result_real, result_imag, divide_by_zero, saturated);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("complex_arith_unit verification failed");
			$finish;
		end
		rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	function logic [31:0] pick_part();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
			4: return $signed($urandom_range(65535)) - 32768;
			5: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input cau_pkg::cmd_t cmd, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		a_real <= ar; a_imag <= ai; b_real <= br; b_imag <= bi;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int n;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = 0; c < 4; c++) begin
			send(cau_pkg::cmd_t'(c), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
				32'h7fff_ffff);
			send(cau_pkg::cmd_t'(c), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000);
			send(cau_pkg::cmd_t'(c), 32'h0001_8000, 32'hfffe_8000, 32'h0000_0000,
				32'h0000_0000);
			send(cau_pkg::cmd_t'(c), 32'hffff_ffff, 32'h0000_0001, 32'h0002_0000,
				32'hffff_0000);
			send(cau_pkg::cmd_t'(c), 32'hfffe_0001, 32'h0000_7fff, 32'h0000_0001,
				32'h0000_0000);
		end
		send(cau_pkg::CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001);
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 100; i++)
				send(cau_pkg::cmd_t'($urandom_range(3)), pick_part(), pick_part(),
					pick_part(), pick_part());
		join
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 26) : 0;
			recv_stall = (ph == 2) ? 88 : ((ph == 3) ? 26 : 0);
			n = (ph == 0) ? 600 : 400;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(15) == 0)
					send(cau_pkg::CMD_DIV, pick_part(), pick_part(), '0, '0);
				else
					send(cau_pkg::cmd_t'($urandom_range(3)), pick_part(), pick_part(),
						pick_part(), pick_part());
			end
			send_idle = 0;
			recv_stall = 0;
		end
		drain();
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("complex_arith_unit verification clean");
		else
			$display("complex_arith_unit verification failed");
		$finish;
	end
endmodule

### filelist.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_setup.sv
design/cau_div_step.sv
design/cau_final.sv
design/complex_arith_unit.sv
bench/tb_top.sv
